// File: rtl/core/stq_pkg.sv
package stq_pkg;

  localparam int unsigned MAX_TIMERS_DEF = 16;
  localparam int unsigned MAX_PROCS_DEF  = 32;

  localparam int unsigned TPS_W     = 14;
  localparam int unsigned PID_W     = 5;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned S_TDATA_W = 72;
  localparam int unsigned M_TDATA_W = 8;

  localparam logic [TPS_W-1:0] TPS_RESET = TPS_W'(1000);

  // floor(x / 1000) == (x * MS_RECIP) >> MS_SHIFT for every 32-bit x
  localparam logic [TIME_W-1:0] MS_RECIP = TIME_W'(274877907);
  localparam int unsigned       MS_SHIFT = 38;

  typedef enum logic [STATUS_W-1:0] {
    STAT_QUEUED = 3'd0,
    STAT_DUE    = 3'd1,
    STAT_FULL   = 3'd2,
    STAT_WOKEN  = 3'd3,
    STAT_NONE   = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_CMP,
    ST_SCAN,
    ST_IRD,
    ST_IWR,
    ST_TICK0,
    ST_TICK1,
    ST_TRD,
    ST_TWR,
    ST_WRD,
    ST_WEV,
    ST_TEND,
    ST_RES
  } state_e;

  typedef struct packed {
    logic [TIME_W-1:0] target;
    logic [PID_W-1:0]  id;
  } waiter_t;

endpackage

// File: rtl/core/stq_ram.sv
module stq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/sleep_timer_queue_core.sv
// sleep request: the target is scaled to jiffies and answered due when not after now, else the
// timers are scanned in order to join a match or reject, else inserted with later timers shifted up;
// tick: none with no timer or no match, else the first timer goes and matched waiters are woken
// one request in work at a time on one shared multiplier and comparator, stores walked per entry
// reset clears the timer and waiter counts and loads a tick rate of 1000 hz;
// the stores are not cleared, entries beyond the counts are never used
module sleep_timer_queue_core #(
  parameter int unsigned MAX_TIMERS = stq_pkg::MAX_TIMERS_DEF,
  parameter int unsigned MAX_PROCS  = stq_pkg::MAX_PROCS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [stq_pkg::TPS_W-1:0]         cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // process_id [4:0], wake_millis [36:5], now_jiffies [68:37], zero [71:69]
  input  logic [stq_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // command [0]
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // woken_id [4:0], zero [7:5]
  output logic [stq_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  // status [2:0]
  output logic [stq_pkg::STATUS_W-1:0]      m_axis_tuser,
  output logic                              m_axis_tlast
);

  import stq_pkg::*;

  localparam int unsigned TIDX_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int unsigned TCNT_W = $clog2(MAX_TIMERS + 1);
  localparam int unsigned WIDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned WCNT_W = $clog2(MAX_PROCS + 1);
  localparam int unsigned WAIT_W = $bits(waiter_t);

  state_e state_q, state_d;

  logic [TPS_W-1:0]  tps_q;
  logic              cmd_q, cmd_d;
  logic [PID_W-1:0]  pid_q, pid_d;
  logic [TIME_W-1:0] millis_q, millis_d;
  logic [TIME_W-1:0] now_q, now_d;
  logic [TIME_W-1:0] prod_q, prod_d;
  logic [TIME_W-1:0] tgt_q, tgt_d;

  logic [TCNT_W-1:0] tcount_q, tcount_d;
  logic [TCNT_W-1:0] pos_q, pos_d;
  logic [TCNT_W-1:0] t_idx_q, t_idx_d;
  logic [WCNT_W-1:0] wcount_q, wcount_d;
  logic [WCNT_W-1:0] w_idx_q, w_idx_d;
  logic [WCNT_W-1:0] keep_q, keep_d;

  status_e          res_status_q, res_status_d;
  logic             pend_valid_q, pend_valid_d;
  logic [PID_W-1:0] pend_id_q, pend_id_d;

  logic             out_valid_q, out_valid_d;
  status_e          out_status_q, out_status_d;
  logic [PID_W-1:0] out_id_q, out_id_d;
  logic             out_last_q, out_last_d;
  logic             out_free;

  logic             emit;
  status_e          emit_status;
  logic [PID_W-1:0] emit_id;
  logic             emit_last;

  // shared arithmetic
  logic [TIME_W-1:0]   mul_a, mul_b;
  logic [2*TIME_W-1:0] mul_p;
  logic [TIME_W-1:0]   cmp_a, cmp_b;
  logic                cmp_lt, cmp_eq;

  // stores
  logic              t_we;
  logic [TIDX_W-1:0] t_waddr, t_raddr;
  logic [TIME_W-1:0] t_wdata, t_rdata;
  logic              w_we;
  logic [WIDX_W-1:0] w_waddr, w_raddr;
  waiter_t           w_wdata, w_rdata;
  logic [WAIT_W-1:0] w_rdata_raw;

  logic [TCNT_W-1:0] pos_inc, t_idx_dec, t_idx_inc;

  stq_ram #(
    .Width (TIME_W),
    .Depth (MAX_TIMERS)
  ) u_timer_ram (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_waddr),
    .wdata_i (t_wdata),
    .raddr_i (t_raddr),
    .rdata_o (t_rdata)
  );

  stq_ram #(
    .Width (WAIT_W),
    .Depth (MAX_PROCS)
  ) u_waiter_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (w_wdata),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata_raw)
  );

  assign w_rdata = waiter_t'(w_rdata_raw);

  assign mul_p  = mul_a * mul_b;
  assign cmp_lt = cmp_a < cmp_b;
  assign cmp_eq = cmp_a == cmp_b;

  assign pos_inc   = pos_q + 1'b1;
  assign t_idx_dec = t_idx_q - 1'b1;
  assign t_idx_inc = t_idx_q + 1'b1;

  assign out_free = !out_valid_q || m_axis_tready;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = M_TDATA_W'(out_id_q);
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

  // operand selection for the shared units
  always_comb begin
    mul_a = millis_q;
    mul_b = TIME_W'(tps_q);
    if (state_q == ST_DIV) begin
      mul_a = prod_q;
      mul_b = MS_RECIP;
    end
    unique case (state_q)
      ST_CMP: begin
        cmp_a = now_q;
        cmp_b = tgt_q;
      end
      ST_TICK1: begin
        cmp_a = t_rdata;
        cmp_b = now_q;
      end
      ST_WEV: begin
        cmp_a = w_rdata.target;
        cmp_b = now_q;
      end
      default: begin
        cmp_a = t_rdata;
        cmp_b = tgt_q;
      end
    endcase
  end

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    pid_d        = pid_q;
    millis_d     = millis_q;
    now_d        = now_q;
    prod_d       = prod_q;
    tgt_d        = tgt_q;
    tcount_d     = tcount_q;
    pos_d        = pos_q;
    t_idx_d      = t_idx_q;
    wcount_d     = wcount_q;
    w_idx_d      = w_idx_q;
    keep_d       = keep_q;
    res_status_d = res_status_q;
    pend_valid_d = pend_valid_q;
    pend_id_d    = pend_id_q;

    emit        = 1'b0;
    emit_status = STAT_NONE;
    emit_id     = '0;
    emit_last   = 1'b1;

    t_we    = 1'b0;
    t_waddr = t_idx_q[TIDX_W-1:0];
    t_wdata = t_rdata;
    t_raddr = '0;
    w_we    = 1'b0;
    w_waddr = wcount_q[WIDX_W-1:0];
    w_wdata = '{target: tgt_q, id: pid_q};
    w_raddr = w_idx_q[WIDX_W-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_d    = s_axis_tuser;
          pid_d    = s_axis_tdata[PID_W-1:0];
          millis_d = s_axis_tdata[PID_W +: TIME_W];
          now_d    = s_axis_tdata[PID_W+TIME_W +: TIME_W];
          state_d  = s_axis_tuser ? ST_TICK0 : ST_MUL;
        end
      end
      ST_MUL: begin
        prod_d  = mul_p[TIME_W-1:0];
        state_d = ST_DIV;
      end
      ST_DIV: begin
        tgt_d   = TIME_W'(mul_p[2*TIME_W-1:MS_SHIFT]);
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (!cmp_lt) begin
          res_status_d = STAT_DUE;
          state_d      = ST_RES;
        end else begin
          pos_d   = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if ((pos_q < tcount_q) && cmp_lt) begin
          pos_d   = pos_inc;
          t_raddr = pos_inc[TIDX_W-1:0];
        end else if (wcount_q >= WCNT_W'(MAX_PROCS)) begin
          res_status_d = STAT_FULL;
          state_d      = ST_RES;
        end else if ((pos_q < tcount_q) && cmp_eq) begin
          w_we         = 1'b1;
          wcount_d     = wcount_q + 1'b1;
          res_status_d = STAT_QUEUED;
          state_d      = ST_RES;
        end else if (tcount_q >= TCNT_W'(MAX_TIMERS)) begin
          res_status_d = STAT_FULL;
          state_d      = ST_RES;
        end else begin
          t_idx_d = tcount_q;
          state_d = ST_IRD;
        end
      end
      ST_IRD: begin
        if (t_idx_q == pos_q) begin
          t_we         = 1'b1;
          t_waddr      = pos_q[TIDX_W-1:0];
          t_wdata      = tgt_q;
          tcount_d     = tcount_q + 1'b1;
          w_we         = 1'b1;
          wcount_d     = wcount_q + 1'b1;
          res_status_d = STAT_QUEUED;
          state_d      = ST_RES;
        end else begin
          t_raddr = t_idx_dec[TIDX_W-1:0];
          state_d = ST_IWR;
        end
      end
      ST_IWR: begin
        t_we    = 1'b1;
        t_idx_d = t_idx_dec;
        state_d = ST_IRD;
      end
      ST_TICK0: begin
        if (tcount_q == '0) begin
          res_status_d = STAT_NONE;
          state_d      = ST_RES;
        end else begin
          state_d = ST_TICK1;
        end
      end
      ST_TICK1: begin
        if (cmp_eq) begin
          t_idx_d = TCNT_W'(1);
          state_d = ST_TRD;
        end else begin
          res_status_d = STAT_NONE;
          state_d      = ST_RES;
        end
      end
      ST_TRD: begin
        if (t_idx_q == tcount_q) begin
          tcount_d     = tcount_q - 1'b1;
          w_idx_d      = '0;
          keep_d       = '0;
          pend_valid_d = 1'b0;
          state_d      = ST_WRD;
        end else begin
          t_raddr = t_idx_q[TIDX_W-1:0];
          state_d = ST_TWR;
        end
      end
      ST_TWR: begin
        t_we    = 1'b1;
        t_waddr = t_idx_dec[TIDX_W-1:0];
        t_idx_d = t_idx_inc;
        state_d = ST_TRD;
      end
      ST_WRD: begin
        state_d = (w_idx_q == wcount_q) ? ST_TEND : ST_WEV;
      end
      ST_WEV: begin
        if (cmp_eq) begin
          // hold the match back until the next one shows whether it is last
          if (!pend_valid_q || out_free) begin
            emit         = pend_valid_q;
            emit_status  = STAT_WOKEN;
            emit_id      = pend_id_q;
            emit_last    = 1'b0;
            pend_valid_d = 1'b1;
            pend_id_d    = w_rdata.id;
            w_idx_d      = w_idx_q + 1'b1;
            state_d      = ST_WRD;
          end
        end else begin
          w_we    = 1'b1;
          w_waddr = keep_q[WIDX_W-1:0];
          w_wdata = w_rdata;
          keep_d  = keep_q + 1'b1;
          w_idx_d = w_idx_q + 1'b1;
          state_d = ST_WRD;
        end
      end
      ST_TEND: begin
        if (out_free) begin
          emit         = 1'b1;
          emit_status  = pend_valid_q ? STAT_WOKEN : STAT_NONE;
          emit_id      = pend_valid_q ? pend_id_q : '0;
          wcount_d     = keep_q;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      ST_RES: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_status = res_status_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_id_d     = out_id_q;
    out_last_d   = out_last_q;
    if (emit) begin
      out_valid_d  = 1'b1;
      out_status_d = emit_status;
      out_id_d     = emit_id;
      out_last_d   = emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      tps_q        <= TPS_RESET;
      tcount_q     <= '0;
      wcount_q     <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      tcount_q     <= tcount_d;
      wcount_q     <= wcount_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        tps_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    pid_q        <= pid_d;
    millis_q     <= millis_d;
    now_q        <= now_d;
    prod_q       <= prod_d;
    tgt_q        <= tgt_d;
    pos_q        <= pos_d;
    t_idx_q      <= t_idx_d;
    w_idx_q      <= w_idx_d;
    keep_q       <= keep_d;
    res_status_q <= res_status_d;
    pend_id_q    <= pend_id_d;
    out_status_q <= out_status_d;
    out_id_q     <= out_id_d;
    out_last_q   <= out_last_d;
  end

  // checks

  a_tcount_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(tcount_q) <= int'(MAX_TIMERS))
    else $error("timer count beyond store depth");

  a_wcount_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(wcount_q) <= int'(MAX_PROCS))
    else $error("waiter count beyond store depth");

  a_every_timer_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(wcount_q) >= int'(tcount_q))
    else $error("timer without a waiter");

  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request taken while one is in work");

  a_pend_scope: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> (state_q == ST_WRD || state_q == ST_WEV || state_q == ST_TEND))
    else $error("held wakeup outside the waiter walk");

  a_tick_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRD || state_q == ST_TRD) |-> cmd_q)
    else $error("waiter walk on a sleep request");

endmodule
